// ===== hw/rtl/kvs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared types and constants for the keyframe vector sampler.
// ----------------------------------------------------------------------------
package kvs_pkg;

  // Default keyframe store depth
  localparam int MAX_KEYS_DEF    = 64;
  // Interpolation needs at least this many keys
  localparam int MIN_INTERP_KEYS = 2;
  // Fraction bits of the 16.16 format and of the 0.16 blend factor
  localparam int FRAC_BITS       = 16;
  // Vector components per key
  localparam int NUM_COMP        = 3;

  // Input item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_SINGLE = 2'd1,
    ST_PAST   = 2'd2,
    ST_BEFORE = 2'd3
  } status_t;

  // Query sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_LERP,
    S_POST
  } state_t;

  // One keyframe as stored: time and xyz value
  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

endpackage

// ===== hw/rtl/kvs_key_mem.sv =====
// ----------------------------------------------------------------------------
// kvs_key_mem
// Keyframe store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvs_key_mem #(
  parameter int DEPTH = kvs_pkg::MAX_KEYS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  kvs_pkg::key_t   wdata,
  input  logic [AW-1:0]   raddr,
  output kvs_pkg::key_t   rdata
);

  kvs_pkg::key_t mem [DEPTH];

  // Write on load, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kvs_div.sv =====
// ----------------------------------------------------------------------------
// kvs_div
// Restoring divider for the blend factor, one quotient bit per cycle.
// Computes floor((num << FRAC_BITS) / den) with num < den.
// ----------------------------------------------------------------------------
module kvs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   num,
  input  logic [31:0]                   den,
  output logic                          done,
  output logic [kvs_pkg::FRAC_BITS-1:0] quo
);

  localparam int CNTW = $clog2(kvs_pkg::FRAC_BITS + 1);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [31:0]     rem;
  logic [31:0]     dq;
  logic [32:0]     shifted;
  logic [32:0]     diff;
  logic            ge;

  // Shift, trial subtract and compare
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dq};
  assign ge      = shifted >= {1'b0, dq};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(kvs_pkg::FRAC_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath; remainder stays below den so it fits 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dq  <= den;
    end else if (run) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      quo <= {quo[kvs_pkg::FRAC_BITS-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/kvs_lerp.sv =====
// ----------------------------------------------------------------------------
// kvs_lerp
// Shared multiplier that blends the three components one after another:
// res = v0 + floor(dv * f / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module kvs_lerp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kvs_pkg::FRAC_BITS-1:0] f,
  input  logic signed [31:0]            v0 [kvs_pkg::NUM_COMP],
  input  logic signed [32:0]            dv [kvs_pkg::NUM_COMP],
  output logic                          done,
  output logic signed [31:0]            res [kvs_pkg::NUM_COMP]
);

  localparam int PW = 33 + kvs_pkg::FRAC_BITS + 1;
  localparam int LAST = kvs_pkg::NUM_COMP - 1;

  logic                 run;
  logic                 pv;
  logic [1:0]           cnt;
  logic [1:0]           pidx;
  logic signed [PW-1:0] prod;
  logic signed [32:0]   dsel;
  logic signed [31:0]   vsel;
  logic signed [PW-1:0] sum;

  // Operand selects for the multiply and add stages
  always_comb begin
    case (cnt)
      2'd0:    dsel = dv[0];
      2'd1:    dsel = dv[1];
      default: dsel = dv[2];
    endcase
    case (pidx)
      2'd0:    vsel = v0[0];
      2'd1:    vsel = v0[1];
      default: vsel = v0[2];
    endcase
  end

  // Arithmetic shift floors toward minus infinity
  assign sum = PW'(vsel) + (prod >>> kvs_pkg::FRAC_BITS);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      pidx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        pv  <= 1'b0;
        cnt <= '0;
      end else begin
        pv   <= run && (cnt != 2'(kvs_pkg::NUM_COMP));
        pidx <= cnt;
        if (run && (cnt != 2'(kvs_pkg::NUM_COMP))) begin
          cnt <= cnt + 2'd1;
        end
        if (pv && (pidx == 2'(LAST))) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiply stage, then add stage
  always_ff @(posedge clk) begin
    prod <= dsel * $signed({1'b0, f});
    if (pv) begin
      res[pidx] <= sum[31:0];
    end
  end

endmodule

// ===== hw/rtl/keyframe_vector_sampler_top.sv =====
// Load item: no result; in_ready stays high.
// Query with N keys in use: a scan over up to N keys (one key per registered read),
// then, when interpolating, the divider (16 quotient bits) and the blend, then the output register.
// One item at a time; in_ready is low until the result sits in the output register.
// Synchronous reset clears control and sets key_count to 1; key store is not cleared.
// ----------------------------------------------------------------------------
// keyframe_vector_sampler_top
// Samples one track of 3-vector keyframes with linear interpolation in 16.16.
// ----------------------------------------------------------------------------
module keyframe_vector_sampler_top #(
  parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: key_count
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [5:0]         key_slot,
  input  logic [31:0]        time_ticks,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [5:0]         base_key,
  output logic [1:0]         status
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int CW  = (NW > 7) ? NW : 7;
  localparam int SW  = (NW > 6) ? NW : 6;

  kvs_pkg::state_t  state, state_next;
  logic [6:0]       key_cnt;
  logic [31:0]      t_q;
  logic [AW-1:0]    last_key;
  logic             single;
  logic [AW-1:0]    j;
  logic [AW-1:0]    chk;
  logic             chk_vld;
  kvs_pkg::key_t    prev;
  kvs_pkg::key_t    rd;
  kvs_pkg::key_t    wr;
  logic signed [31:0] v0 [kvs_pkg::NUM_COMP];
  logic signed [32:0] dv [kvs_pkg::NUM_COMP];
  logic signed [31:0] lres [kvs_pkg::NUM_COMP];
  logic [kvs_pkg::FRAC_BITS-1:0] fac;
  logic signed [31:0] rx, ry, rz;
  logic [5:0]       rbase;
  kvs_pkg::status_t rstat;
  logic signed [31:0] ox, oy, oz;
  logic [5:0]       obase;
  kvs_pkg::status_t ostat;

  logic             in_acc;
  logic             mem_we;
  logic             slot_ok;
  logic [CW-1:0]    kc_w;
  logic [CW-1:0]    n_c;
  logic             scan_chk;
  logic             chk_zero;
  logic             t_lt;
  logic             hit_single, hit_before, hit_past, found, early;
  logic             div_done, lerp_start, lerp_done;
  logic             out_free;
  logic             post_load;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == kvs_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Effective key count, clamped to 1..MAX_KEYS
  assign kc_w    = CW'(key_cnt);
  assign n_c     = (kc_w == '0) ? CW'(1) :
                   ((kc_w > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : kc_w);
  assign slot_ok = SW'(key_slot) < SW'(MAX_KEYS);

  // Key store
  always_comb begin
    wr.tick = time_ticks;
    wr.x    = value_x;
    wr.y    = value_y;
    wr.z    = value_z;
  end

  kvs_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(key_slot)),
    .wdata (wr),
    .raddr (j),
    .rdata (rd)
  );

  // Scan decisions on the key whose data is in rd
  assign scan_chk   = (state == kvs_pkg::S_SCAN) && chk_vld;
  assign chk_zero   = (chk == '0);
  assign t_lt       = t_q < rd.tick;
  assign hit_single = scan_chk && chk_zero && single;
  assign hit_before = scan_chk && chk_zero && !single && t_lt;
  assign found      = scan_chk && !chk_zero && t_lt;
  assign hit_past   = scan_chk && !chk_zero && !t_lt && (chk == last_key);
  assign early      = hit_single || hit_before || hit_past;

  // Blend factor divider
  kvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (found),
    .num   (t_q - prev.tick),
    .den   (rd.tick - prev.tick),
    .done  (div_done),
    .quo   (fac)
  );

  // Component blend
  kvs_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .f     (fac),
    .v0    (v0),
    .dv    (dv),
    .done  (lerp_done),
    .res   (lres)
  );

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    lerp_start = 1'b0;
    post_load  = 1'b0;
    unique case (state)
      kvs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (kind == kvs_pkg::KIND_QUERY) begin
            state_next = kvs_pkg::S_SCAN;
          end else begin
            mem_we = slot_ok;
          end
        end
      end
      kvs_pkg::S_SCAN: begin
        if (found) begin
          state_next = kvs_pkg::S_DIV;
        end else if (early) begin
          state_next = kvs_pkg::S_POST;
        end
      end
      kvs_pkg::S_DIV: begin
        if (div_done) begin
          lerp_start = 1'b1;
          state_next = kvs_pkg::S_LERP;
        end
      end
      kvs_pkg::S_LERP: begin
        if (lerp_done) begin
          state_next = kvs_pkg::S_POST;
        end
      end
      kvs_pkg::S_POST: begin
        if (out_free) begin
          post_load  = 1'b1;
          state_next = kvs_pkg::S_IDLE;
        end
      end
      default: state_next = kvs_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvs_pkg::S_IDLE;
      key_cnt   <= 7'd1;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        key_cnt <= cfg_data;
      end
      if (post_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        chk_vld <= 1'b0;
      end else if (state == kvs_pkg::S_SCAN) begin
        chk_vld <= 1'b1;
      end
    end
  end

  // Query setup and scan walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_q      <= time_ticks;
      last_key <= AW'(n_c - CW'(1));
      single   <= n_c < CW'(kvs_pkg::MIN_INTERP_KEYS);
      j        <= '0;
    end else if (state == kvs_pkg::S_SCAN) begin
      chk  <= j;
      prev <= rd;
      if (j != last_key) begin
        j <= j + AW'(1);
      end
    end
  end

  // Bracketing pair: base value and deltas for the blend
  always_ff @(posedge clk) begin
    if (found) begin
      v0[0] <= prev.x;
      v0[1] <= prev.y;
      v0[2] <= prev.z;
      dv[0] <= {rd.x[31], rd.x} - {prev.x[31], prev.x};
      dv[1] <= {rd.y[31], rd.y} - {prev.y[31], prev.y};
      dv[2] <= {rd.z[31], rd.z} - {prev.z[31], prev.z};
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (found) begin
      rbase <= 6'(chk - AW'(1));
    end else if (early) begin
      rx <= rd.x;
      ry <= rd.y;
      rz <= rd.z;
      if (hit_past) begin
        rbase <= 6'(last_key);
        rstat <= kvs_pkg::ST_PAST;
      end else begin
        rbase <= 6'd0;
        rstat <= hit_single ? kvs_pkg::ST_SINGLE : kvs_pkg::ST_BEFORE;
      end
    end else if (lerp_done) begin
      rx    <= lres[0];
      ry    <= lres[1];
      rz    <= lres[2];
      rstat <= kvs_pkg::ST_INTERP;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (post_load) begin
      ox    <= rx;
      oy    <= ry;
      oz    <= rz;
      obase <= rbase;
      ostat <= rstat;
    end
  end

  assign out_x    = ox;
  assign out_y    = oy;
  assign out_z    = oz;
  assign base_key = obase;
  assign status   = ostat;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyframe_vector_sampler_top.
// Directed tests cover a single held key, the zero count clamp, full-range blends,
// sample times before the first and past the last key, and unordered keys.
// Random tracks of sorted or shuffled keys with queries inside, before, after
// and exactly on key times then run under four phases of sender and receiver
// idling. Every sampled vector is checked against a track model in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int   RESET_CYCLES = 7;
  // covers the longest query; rounded up
  localparam int   DRAIN_CYCLES = kvs_pkg::MAX_KEYS_DEF + 40;
  localparam int   RANDOM_ITEMS = 1200;
  localparam int   REPORT_LIMIT = 10;
  // expected results waiting for their transfer
  localparam int   PEND_DEPTH   = 16;

  // one sampled vector as the block reports it
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [5:0]         base;
    kvs_pkg::status_t   st;
  } sample_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               kind       = 1'b0;
  logic [5:0]         key_slot   = '0;
  logic [31:0]        time_ticks = '0;
  logic signed [31:0] value_x    = '0;
  logic signed [31:0] value_y    = '0;
  logic signed [31:0] value_z    = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [5:0]         base_key;
  logic [1:0]         status;

  // bench copy of the track
  logic [31:0]        key_time_mem [kvs_pkg::MAX_KEYS_DEF];
  logic signed [31:0] key_x_mem    [kvs_pkg::MAX_KEYS_DEF];
  logic signed [31:0] key_y_mem    [kvs_pkg::MAX_KEYS_DEF];
  logic signed [31:0] key_z_mem    [kvs_pkg::MAX_KEYS_DEF];
  logic [6:0]         key_count_m = 7'd1;

  sample_t     pend_mem [PEND_DEPTH];
  int          pend_wr        = 0;
  int          pend_rd        = 0;
  sample_t     want;
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          send_idle_pct  = 0;
  int          rcv_stall_pct  = 0;
  logic [31:0] track_lo;
  logic [31:0] track_hi;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyframe_vector_sampler_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .key_slot   (key_slot),
    .time_ticks (time_ticks),
    .value_x    (value_x),
    .value_y    (value_y),
    .value_z    (value_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .base_key   (base_key),
    .status     (status)
  );

  // ---------------------------------------------------------------------------
  // Track model
  // ---------------------------------------------------------------------------

  // count in use: 0 acts as 1, anything above the store depth as the depth
  function automatic int keys_in_use(input logic [6:0] c);
    if (c == 0) return 1;
    if (c > kvs_pkg::MAX_KEYS_DEF) return kvs_pkg::MAX_KEYS_DEF;
    return int'(c);
  endfunction

  function automatic sample_t hold_key(input int k, input kvs_pkg::status_t st);
    sample_t r;
    r.x    = key_x_mem[k];
    r.y    = key_y_mem[k];
    r.z    = key_z_mem[k];
    r.base = 6'(k);
    r.st   = st;
    return r;
  endfunction

  // v0 + floor((v1 - v0) * f / 2^16)
  function automatic logic [31:0] blend(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic [31:0] f);
    longint v0;
    longint ff;
    longint p;
    v0 = a;
    ff = f;
    p  = (b - v0) * ff;
    return 32'(v0 + (p >>> kvs_pkg::FRAC_BITS));
  endfunction

  function automatic sample_t sample_track(input logic [31:0] t);
    sample_t     r;
    int          n;
    int          i;
    logic [31:0] dt;
    logic [31:0] span;
    logic [63:0] num;
    logic [31:0] f;
    n = keys_in_use(key_count_m);
    if (n < kvs_pkg::MIN_INTERP_KEYS) return hold_key(0, kvs_pkg::ST_SINGLE);
    if (t < key_time_mem[0]) return hold_key(0, kvs_pkg::ST_BEFORE);
    i = 0;
    while (i + 1 < n && !(t < key_time_mem[i + 1])) i++;
    if (i + 1 >= n) return hold_key(n - 1, kvs_pkg::ST_PAST);
    // here t0 <= t < t1
    dt   = t - key_time_mem[i];
    span = key_time_mem[i + 1] - key_time_mem[i];
    num  = {16'h0, dt, 16'h0};
    f    = 32'(num / {32'h0, span});
    r.x    = blend(key_x_mem[i], key_x_mem[i + 1], f);
    r.y    = blend(key_y_mem[i], key_y_mem[i + 1], f);
    r.z    = blend(key_z_mem[i], key_z_mem[i + 1], f);
    r.base = 6'(i);
    r.st   = kvs_pkg::ST_INTERP;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // one input transfer; the model is updated when it is accepted
  task automatic send_item(input logic k, input logic [5:0] slot, input logic [31:0] t,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    key_slot   <= slot;
    time_ticks <= t;
    value_x    <= x;
    value_y    <= y;
    value_z    <= z;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (k == kvs_pkg::KIND_LOAD) begin
      key_time_mem[slot] = t;
      key_x_mem[slot]    = x;
      key_y_mem[slot]    = y;
      key_z_mem[slot]    = z;
    end else begin
      pend_mem[pend_wr % PEND_DEPTH] = sample_track(t);
      pend_wr++;
    end
  endtask

  task automatic load_key(input logic [5:0] slot, input logic [31:0] t,
                          input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z);
    send_item(kvs_pkg::KIND_LOAD, slot, t, x, y, z);
  endtask

  // slot and value fields are unused by a query; fill them with noise
  task automatic sample_at(input logic [31:0] t);
    send_item(kvs_pkg::KIND_QUERY, 6'($urandom), t, $urandom, $urandom, $urandom);
  endtask

  // key_count is written only with the block idle
  task automatic set_key_count(input logic [6:0] c);
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    key_count_m = c;
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 1) != 0) return $urandom;
    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
  endfunction

  // fill slots 0..n-1; mostly ascending times, sometimes shuffled
  task automatic build_track(input int n);
    logic [31:0] t;
    logic [31:0] step_max;
    longint      room;
    int          r;
    bit          ordered;
    ordered  = $urandom_range(0, 99) < 85;
    r        = $urandom_range(0, 2);
    step_max = (r == 0) ? 32'd4 : (r == 1) ? 32'd65536 : 32'hFFFF_FFFF / (n + 1);
    room     = longint'(32'hFFFF_FFFF) - longint'(n) * longint'(step_max);
    t        = $urandom_range(0, 32'(room));
    track_lo = '1;
    track_hi = '0;
    for (int k = 0; k < n; k++) begin
      if (!ordered) t = $urandom;
      load_key(6'(k), t, rand_value(), rand_value(), rand_value());
      if (t < track_lo) track_lo = t;
      if (t > track_hi) track_hi = t;
      if (ordered) t = t + $urandom_range(0, step_max);
    end
  endtask

  // queries around the track, with a few stray loads mixed in
  task automatic run_queries(input int n);
    int r;
    repeat ($urandom_range(8, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 6)
        load_key(6'($urandom), $urandom, $urandom, $urandom, $urandom);
      else if (r < 14)
        sample_at(track_lo == 0 ? 32'h0 : $urandom_range(0, track_lo - 1));
      else if (r < 22)
        sample_at($urandom_range(track_hi, 32'hFFFF_FFFF));
      else if (r < 30)
        sample_at(key_time_mem[$urandom_range(0, n - 1)]);
      else
        sample_at($urandom_range(track_lo, track_hi));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // count 1 after reset, and count 0, hold key 0
  task automatic test_single_key();
    load_key(6'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    set_key_count(7'd0);
    sample_at(32'h1234_5678);
  endtask

  // widest possible time span and value swing, both signs
  task automatic test_interp_extremes();
    set_key_count(7'd2);
    load_key(6'd0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    load_key(6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    sample_at(32'h0);
    sample_at(32'h7FFF_FFFF);
    sample_at(32'hFFFF_FFFE);
    sample_at(32'hFFFF_FFFF);
  endtask

  task automatic test_before_first();
    load_key(6'd0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    sample_at(32'h0);
    sample_at(32'h0000_FFFF);
    sample_at(32'h0001_0000);
  endtask

  // last key lies below key 1, so the scan runs past it
  task automatic test_unordered_keys();
    set_key_count(7'd3);
    load_key(6'd2, 32'h0002_0000, 32'h0, 32'h0, 32'h0);
    sample_at(32'h0001_8000);
    sample_at(32'hFFFF_FFFF);
    sample_at(32'h0);
  endtask

  task automatic test_random_tracks();
    int first;
    int c;
    int r;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  c = 64;  end
        1: begin send_idle_pct = 58; rcv_stall_pct = 0;  c = 127; end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 58; c = 1;   end
        default: begin send_idle_pct = 8; rcv_stall_pct = 8; c = 2; end
      endcase
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS / 4) begin
        set_key_count(7'(c));
        build_track(keys_in_use(7'(c)));
        run_queries(keys_in_use(7'(c)));
        // mostly short tracks, now and then the extremes
        r = $urandom_range(0, 99);
        if (r < 4)       c = $urandom_range(0, 1);
        else if (r < 9)  c = 64;
        else if (r < 12) c = $urandom_range(65, 127);
        else             c = $urandom_range(2, 12);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // compare each result transfer with the oldest pending sample
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pend_wr == pend_rd) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: x %h y %h z %h base %0d status %0d",
                   $time, out_x, out_y, out_z, base_key, status);
      end else begin
        want = pend_mem[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
            base_key !== want.base || status !== want.st) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch: want x %h y %h z %h base %0d status %0d", $time,
                     want.x, want.y, want.z, want.base, want.st);
            $display("%0t:            got x %h y %h z %h base %0d status %0d", $time,
                     out_x, out_y, out_z, base_key, status);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_single_key();
    test_interp_extremes();
    test_before_first();
    test_unordered_keys();
    test_random_tracks();
    in_valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** keyframe_vector_sampler_top: PASSED **");
    else
      $display("** keyframe_vector_sampler_top: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("** keyframe_vector_sampler_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kvs_pkg.sv
hw/rtl/kvs_key_mem.sv
hw/rtl/kvs_div.sv
hw/rtl/kvs_lerp.sv
hw/rtl/keyframe_vector_sampler_top.sv
bench/tb_top.sv
